// ===== rtl/core/gcd_pkg.sv =====
// Shared types, constants and helper functions for the great-circle distance pipeline.
// Used by gcd_sincos, gcd_acos and great_circle_distance_top; depends on nothing.
package gcd_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int XW                = 34;
    localparam int SQRT_STEPS        = 31;

    localparam int SC_LATENCY   = CORDIC_STAGES + 1;
    localparam int ACOS_LATENCY = SQRT_STEPS + CORDIC_STAGES + 3;
    localparam int PIPE_DEPTH   = 1 + SC_LATENCY + 3 + ACOS_LATENCY + 2;

    typedef logic signed [XW-1:0] cval_t;

    localparam cval_t               CORDIC_GAIN  = 34'sd652032874;
    localparam cval_t               ONE_Q30      = 34'sd1073741824;
    localparam logic signed [25:0]  DEG_TO_TURN  = 26'sd11930465;
    localparam logic [31:0]         DIST_SCALE   = 32'd2623417457;
    localparam logic [31:0]         QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0]         HALF_TURN    = 32'h8000_0000;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            5'd30:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic cval_t mul_q30(input cval_t a, input cval_t b);
        logic signed [2*XW-1:0] p;
        p = $signed((2*XW)'(a)) * $signed((2*XW)'(b)) + (2*XW)'(64'sd536870912);
        return XW'(p >>> 30);
    endfunction

endpackage

// ===== rtl/core/gcd_sincos.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a 32-bit binary angle in Q30.
// Depends on gcd_pkg; one pre-rotation stage plus one register stage per iteration.
module gcd_sincos import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] angle,
    output cval_t       sin_val,
    output cval_t       cos_val
);

    logic        flip_reg;
    cval_t       z0_reg;
    logic        fold;
    logic [31:0] p_adj;

    cval_t x_reg [0:CORDIC_STAGES-1];
    cval_t y_reg [0:CORDIC_STAGES-1];
    cval_t z_reg [0:CORDIC_STAGES-1];
    logic  f_reg [0:CORDIC_STAGES-1];

    always_comb
    begin
        fold  = logic'((angle + QUARTER_TURN) >> 31);
        p_adj = fold ? angle + HALF_TURN : angle;
    end

    // fold the angle into the right half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg <= fold;
            z0_reg   <= cval_t'($signed(p_adj));
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_iter
            cval_t x_in, y_in, z_in, at, x_next, y_next, z_next;
            logic  f_in;
            if (i == 0)
            begin : g_first
                assign x_in = CORDIC_GAIN;
                assign y_in = '0;
                assign z_in = z0_reg;
                assign f_in = flip_reg;
            end
            else
            begin : g_rest
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign f_in = f_reg[i-1];
            end
            assign at = cval_t'({2'b00, atan_turn(5'(i))});
            always_comb
            begin
                if (!z_in[XW-1])
                begin
                    x_next = x_in - (y_in >>> i);
                    y_next = y_in + (x_in >>> i);
                    z_next = z_in - at;
                end
                else
                begin
                    x_next = x_in + (y_in >>> i);
                    y_next = y_in - (x_in >>> i);
                    z_next = z_in + at;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                    z_reg[i] <= z_next;
                    f_reg[i] <= f_in;
                end
            end
        end
    endgenerate

    assign sin_val = f_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1] : y_reg[CORDIC_STAGES-1];
    assign cos_val = f_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1] : x_reg[CORDIC_STAGES-1];

endmodule

// ===== rtl/core/gcd_acos.sv =====
// Pipelined arc cosine of a Q30 value in [-1,1]: square, one-bit-per-stage square root,
// vectoring CORDIC and final clamp/mirror to a binary angle. Depends on gcd_pkg.
module gcd_acos import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] c_val,
    output logic [31:0]        angle
);

    logic        neg0_reg, neg1_reg;
    logic [30:0] abs0_reg, abs1_reg;
    logic [61:0] sq_reg, v_reg;
    logic [30:0] abs_c;

    logic [31:0] rem_reg  [0:SQRT_STEPS-1];
    logic [30:0] root_reg [0:SQRT_STEPS-1];
    logic [61:0] vr_reg   [0:SQRT_STEPS-1];
    logic [30:0] sa_reg   [0:SQRT_STEPS-1];
    logic        sn_reg   [0:SQRT_STEPS-1];

    cval_t vx_reg [0:CORDIC_STAGES-1];
    cval_t vy_reg [0:CORDIC_STAGES-1];
    cval_t vz_reg [0:CORDIC_STAGES-1];
    logic  vn_reg [0:CORDIC_STAGES-1];

    logic [31:0] angle_reg;
    cval_t       z_fin;
    logic [31:0] z_clamp;

    assign abs_c = c_val[31] ? 31'(-c_val) : 31'(c_val);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= c_val[31];
            abs0_reg <= abs_c;
            sq_reg   <= 62'(abs_c) * 62'(abs_c);
            neg1_reg <= neg0_reg;
            abs1_reg <= abs0_reg;
            v_reg    <= (62'd1 << 60) - sq_reg;
        end
    end

    genvar k, i;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt
            logic [31:0] rem_in;
            logic [30:0] root_in, sa_in;
            logic [61:0] vr_in;
            logic        sn_in, ge;
            logic [33:0] cat, trial;
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign vr_in   = v_reg;
                assign sa_in   = abs1_reg;
                assign sn_in   = neg1_reg;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign vr_in   = vr_reg[k-1];
                assign sa_in   = sa_reg[k-1];
                assign sn_in   = sn_reg[k-1];
            end
            assign cat   = {rem_in, vr_in[61:60]};
            assign trial = {1'b0, root_in, 2'b01};
            assign ge    = (cat >= trial);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? 32'(cat - trial) : 32'(cat);
                    root_reg[k] <= {root_in[29:0], ge};
                    vr_reg[k]   <= {vr_in[59:0], 2'b00};
                    sa_reg[k]   <= sa_in;
                    sn_reg[k]   <= sn_in;
                end
            end
        end

        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_vec
            cval_t x_in, y_in, z_in, at, x_next, y_next, z_next;
            logic  n_in;
            if (i == 0)
            begin : g_first
                assign x_in = cval_t'({1'b0, sa_reg[SQRT_STEPS-1]});
                assign y_in = cval_t'({1'b0, root_reg[SQRT_STEPS-1]});
                assign z_in = '0;
                assign n_in = sn_reg[SQRT_STEPS-1];
            end
            else
            begin : g_rest
                assign x_in = vx_reg[i-1];
                assign y_in = vy_reg[i-1];
                assign z_in = vz_reg[i-1];
                assign n_in = vn_reg[i-1];
            end
            assign at = cval_t'({2'b00, atan_turn(5'(i))});
            always_comb
            begin
                if (y_in > 0)
                begin
                    x_next = x_in + (y_in >>> i);
                    y_next = y_in - (x_in >>> i);
                    z_next = z_in + at;
                end
                else
                begin
                    x_next = x_in - (y_in >>> i);
                    y_next = y_in + (x_in >>> i);
                    z_next = z_in - at;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vx_reg[i] <= x_next;
                    vy_reg[i] <= y_next;
                    vz_reg[i] <= z_next;
                    vn_reg[i] <= n_in;
                end
            end
        end
    endgenerate

    // clamp to a quarter turn, then mirror for negative input
    always_comb
    begin
        z_fin = vz_reg[CORDIC_STAGES-1];
        if (z_fin[XW-1])
            z_clamp = '0;
        else if (z_fin > cval_t'({2'b00, QUARTER_TURN}))
            z_clamp = QUARTER_TURN;
        else
            z_clamp = z_fin[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= vn_reg[CORDIC_STAGES-1] ? HALF_TURN - z_clamp : z_clamp;
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/core/great_circle_distance_top.sv =====
// Great-circle distance top level: converts coordinates, runs the trig pipelines and scales.
// Depends on gcd_pkg, gcd_sincos and gcd_acos.
//
// Input channel: in_valid/in_ready with origin and destination latitude and longitude,
// signed degrees with 16 fraction bits. Output channel: out_valid/out_ready with
// distance_km, unsigned kilometres with 8 fraction bits.
// Every input transaction yields exactly one output transaction, in order.
// From acceptance until the result can be taken, a transaction passes through the angle
// registers, the sine/cosine CORDIC chains, the combining stages, the 31-step square root
// and vectoring CORDIC of the arc cosine and the scaling registers, one register stage per step.
// Throughput: one transaction per cycle while out_ready is high.
// The whole pipeline advances on a single enable; when out_valid is high and out_ready is
// low, every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and in_ready is high afterward.
module great_circle_distance_top import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] origin_latitude,
    input  logic [24:0] origin_longitude,
    input  logic [23:0] dest_latitude,
    input  logic [24:0] dest_longitude,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [22:0] distance_km
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;

    logic signed [25:0] lat1, lat2, dlon;
    logic signed [50:0] p1, p2, pd;
    logic [31:0]        a1_reg, a2_reg, ad_reg;

    cval_t s1, c1, s2, c2, sd, cd;
    cval_t mss_reg, mcc_reg, cd_reg, mss2_reg, m3_reg;
    logic signed [XW:0]  sum;
    logic signed [31:0]  c_reg;
    logic [31:0]         ang;
    logic [63:0]         prod_reg;
    logic [64:0]         rnd;
    logic [22:0]         dist_reg;

    assign en       = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = en;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // degrees to binary angle
    always_comb
    begin
        lat1 = 26'($signed(origin_latitude));
        lat2 = 26'($signed(dest_latitude));
        dlon = 26'($signed(dest_longitude)) - 26'($signed(origin_longitude));
        p1   = 51'(lat1) * 51'(DEG_TO_TURN) + 51'sd32768;
        p2   = 51'(lat2) * 51'(DEG_TO_TURN) + 51'sd32768;
        pd   = 51'(dlon) * 51'(DEG_TO_TURN) + 51'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= p1[47:16];
            a2_reg <= p2[47:16];
            ad_reg <= pd[47:16];
        end
    end

    gcd_sincos u_sc_lat1 (.clk(clk), .en(en), .angle(a1_reg), .sin_val(s1), .cos_val(c1));
    gcd_sincos u_sc_lat2 (.clk(clk), .en(en), .angle(a2_reg), .sin_val(s2), .cos_val(c2));
    gcd_sincos u_sc_dlon (.clk(clk), .en(en), .angle(ad_reg), .sin_val(sd), .cos_val(cd));

    always_comb
    begin
        sum = (XW+1)'(mss2_reg) + (XW+1)'(m3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mss_reg  <= mul_q30(s1, s2);
            mcc_reg  <= mul_q30(c1, c2);
            cd_reg   <= cd;
            mss2_reg <= mss_reg;
            m3_reg   <= mul_q30(mcc_reg, cd_reg);
            if (sum > (XW+1)'(ONE_Q30))
                c_reg <= 32'(ONE_Q30);
            else if (sum < -(XW+1)'(ONE_Q30))
                c_reg <= -32'(ONE_Q30);
            else
                c_reg <= 32'(sum);
        end
    end

    gcd_acos u_acos (.clk(clk), .en(en), .c_val(c_reg), .angle(ang));

    assign rnd = 65'(prod_reg) + (65'd1 << 39);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 64'(ang) * 64'(DIST_SCALE);
            dist_reg <= rnd[62:40];
        end
    end

    assign out_valid   = valid_reg[PIPE_DEPTH-1];
    assign distance_km = dist_reg;

endmodule
